### design/srt_pkg.sv
// shared types and constants for the sorted reminder table
package srt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [13:0] MAX_YEAR = 14'd9999;
	localparam logic [5:0] MAX_DAY = 6'd31;
	localparam logic [4:0] HOUR_LIMIT = 5'd24;
	localparam logic [5:0] MINUTE_LIMIT = 6'd60;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL    = 3'd2,
		ST_LISTED  = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INS,
		S_DUMP
	} state_t;

	typedef struct packed {
		logic [13:0] year;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic insert;
		logic rotate;
	} cell_cmd_t;

	localparam int KEY_W = $bits(entry_t) - 16;

endpackage

### design/srt_cell.sv
// one table cell: holds an entry, compares against a new key, shifts or rotates
module srt_cell (
	input  logic               clk,
	input  srt_pkg::cell_cmd_t cmd,
	input  logic               occ,
	input  logic               tail,
	input  srt_pkg::entry_t    new_entry,
	input  srt_pkg::entry_t    prev_entry,
	input  logic               prev_at,
	input  srt_pkg::entry_t    next_entry,
	input  srt_pkg::entry_t    head_entry,
	output srt_pkg::entry_t    entry,
	output logic               at
);

	srt_pkg::entry_t entry_q;
	logic [srt_pkg::KEY_W-1:0] own_key;
	logic [srt_pkg::KEY_W-1:0] new_key;

	assign own_key = entry_q[$bits(srt_pkg::entry_t)-1:16];
	assign new_key = new_entry[$bits(srt_pkg::entry_t)-1:16];

	// at or past the insert point
	assign at = !occ || (own_key >= new_key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			if (prev_at) begin
				entry_q <= prev_entry;
			end else if (at) begin
				entry_q <= new_entry;
			end
		end else if (cmd.rotate) begin
			entry_q <= tail ? head_entry : next_entry;
		end
	end

endmodule

### design/sorted_reminder_table.sv
// sorted reminder table: top level with control and the row of cells
//
// Input channel (in_valid/in_ready) takes one item: mode 0 inserts an entry
// given by year, day, hour, minute and tag; mode 1 lists the whole table.
// Output channel (out_valid/out_ready) returns results with a status code;
// last marks the final result of an item.
// An insert is checked for a full table, then for range, and the entry goes
// in front of the first stored entry with an equal or greater key. Every cell
// compares its key with the new one at once; the cell at the insert point takes
// the new entry and cells past it take their neighbour's entry in the same cycle.
// An insert moves to the insert state and, once the output register is free,
// writes its result there, stores the entry if it passed the checks and returns to idle.
// A listing rotates the row of cells by one place per cycle while the output
// register is free, reading cell 0 for each result (an empty table gives a single
// empty result); the rotation ends with the table back in its original order.
// One item is worked on at a time; in_ready is high only when idle.
// A single output register holds each result; while the receiver stalls the
// block holds the result and pauses the rotation or insert.
// Reset empties the table at once (entry count to zero); no clearing pass.
module sorted_reminder_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [13:0] year,
	input  logic [5:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [15:0] tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [13:0] out_year,
	output logic [4:0]  out_day,
	output logic [4:0]  out_hour,
	output logic [5:0]  out_minute,
	output logic [15:0] out_tag,
	output logic        last
);

	srt_pkg::state_t state_q, state_d;
	logic [srt_pkg::CNT_W-1:0] count_q;
	logic [srt_pkg::CNT_W-1:0] idx_q;
	logic [srt_pkg::CNT_W-1:0] count_m1;
	srt_pkg::entry_t req_entry_q;
	logic req_ok_q;

	logic out_valid_q;
	srt_pkg::status_t status_q;
	srt_pkg::entry_t out_entry_q;
	logic last_q;

	logic accept, out_free, emit, full, empty, dump_end;
	srt_pkg::cell_cmd_t cmd;
	srt_pkg::status_t emit_status;
	srt_pkg::entry_t emit_entry;
	logic emit_last;

	srt_pkg::entry_t cell_entry [srt_pkg::TABLE_DEPTH];
	logic cell_at [srt_pkg::TABLE_DEPTH];

	assign accept = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign full = (count_q == srt_pkg::CNT_W'(srt_pkg::TABLE_DEPTH));
	assign empty = (count_q == '0);
	assign count_m1 = count_q - srt_pkg::CNT_W'(1);
	assign dump_end = empty || (idx_q == count_m1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srt_pkg::S_IDLE: begin
				if (accept) begin
					state_d = mode ? srt_pkg::S_DUMP : srt_pkg::S_INS;
				end
			end
			srt_pkg::S_INS: begin
				if (out_free) begin
					state_d = srt_pkg::S_IDLE;
				end
			end
			srt_pkg::S_DUMP: begin
				if (out_free && dump_end) begin
					state_d = srt_pkg::S_IDLE;
				end
			end
			default: state_d = srt_pkg::S_IDLE;
		endcase
	end

	// outputs of the control
	always_comb begin
		in_ready = 1'b0;
		emit = 1'b0;
		cmd = '0;
		emit_status = srt_pkg::ST_STORED;
		emit_entry = '0;
		emit_last = 1'b1;
		unique case (state_q)
			srt_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			srt_pkg::S_INS: begin
				emit = out_free;
				if (full) begin
					emit_status = srt_pkg::ST_FULL;
				end else if (!req_ok_q) begin
					emit_status = srt_pkg::ST_INVALID;
				end else begin
					emit_status = srt_pkg::ST_STORED;
					cmd.insert = out_free;
				end
			end
			srt_pkg::S_DUMP: begin
				emit = out_free;
				if (empty) begin
					emit_status = srt_pkg::ST_EMPTY;
				end else begin
					emit_status = srt_pkg::ST_LISTED;
					emit_entry = cell_entry[0];
					emit_last = (idx_q == count_m1);
					cmd.rotate = out_free;
				end
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srt_pkg::S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.insert) begin
				count_q <= count_q + srt_pkg::CNT_W'(1);
			end
			if (cmd.rotate) begin
				idx_q <= emit_last ? '0 : idx_q + srt_pkg::CNT_W'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_entry_q <= {year, day[4:0], hour, minute, tag};
			req_ok_q <= (year != '0) && (year <= srt_pkg::MAX_YEAR) &&
				(day <= srt_pkg::MAX_DAY) && (hour < srt_pkg::HOUR_LIMIT) &&
				(minute < srt_pkg::MINUTE_LIMIT);
		end
		if (emit) begin
			status_q <= emit_status;
			out_entry_q <= emit_entry;
			last_q <= emit_last;
		end
	end

	// row of cells
	for (genvar i = 0; i < srt_pkg::TABLE_DEPTH; i++) begin : g_cell
		srt_pkg::entry_t prev_e, next_e;
		logic prev_a;
		if (i == 0) begin : g_first
			assign prev_e = req_entry_q;
			assign prev_a = 1'b0;
		end else begin : g_mid
			assign prev_e = cell_entry[i-1];
			assign prev_a = cell_at[i-1];
		end
		if (i == srt_pkg::TABLE_DEPTH - 1) begin : g_end
			assign next_e = cell_entry[0];
		end else begin : g_inner
			assign next_e = cell_entry[i+1];
		end
		srt_cell u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.occ        (count_q > srt_pkg::CNT_W'(i)),
			.tail       (count_m1 == srt_pkg::CNT_W'(i)),
			.new_entry  (req_entry_q),
			.prev_entry (prev_e),
			.prev_at    (prev_a),
			.next_entry (next_e),
			.head_entry (cell_entry[0]),
			.entry      (cell_entry[i]),
			.at         (cell_at[i])
		);
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_year = out_entry_q.year;
	assign out_day = out_entry_q.day;
	assign out_hour = out_entry_q.hour;
	assign out_minute = out_entry_q.minute;
	assign out_tag = out_entry_q.tag;
	assign last = last_q;

endmodule

### design/srt_checker.sv
// port checks for the sorted reminder table, bound to the top level
module srt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  status,
	input logic [13:0] out_year,
	input logic [4:0]  out_day,
	input logic [4:0]  out_hour,
	input logic [5:0]  out_minute,
	input logic [15:0] out_tag,
	input logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(out_tag) && $stable(last))
		else $error("result changed while stalled");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != srt_pkg::ST_LISTED) |-> last)
		else $error("status result without last");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != srt_pkg::ST_LISTED) |->
		(out_year == '0) && (out_day == '0) && (out_hour == '0) &&
		(out_minute == '0) && (out_tag == '0))
		else $error("non-listed result carries entry fields");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous item in work");

endmodule

bind sorted_reminder_table srt_checker u_srt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.status     (status),
	.out_year   (out_year),
	.out_day    (out_day),
	.out_hour   (out_hour),
	.out_minute (out_minute),
	.out_tag    (out_tag),
	.last       (last)
);

### tb/testbench.sv
// testbench for the sorted reminder table: queued items, bursty driver, stalling receiver, checker
`timescale 1ns / 100ps

module testbench;

	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER = 30;
	localparam int RANDOM_ITEMS = 450;

	typedef enum int {
		RX_FREE,
		RX_PATTERN,
		RX_SPARSE
	} rx_style_t;

	typedef struct {
		bit          mode;
		logic [13:0] year;
		logic [5:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] tag;
		bit          drain;
	} request_t;

	typedef struct {
		srt_pkg::status_t status;
		logic [13:0] year;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [15:0] tag;
		logic        last;
	} reply_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = 1'b0;
	logic [13:0] year = '0;
	logic [5:0]  day = '0;
	logic [4:0]  hour = '0;
	logic [5:0]  minute = '0;
	logic [15:0] tag = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [13:0] out_year;
	logic [4:0]  out_day;
	logic [4:0]  out_hour;
	logic [5:0]  out_minute;
	logic [15:0] out_tag;
	logic        last;

	request_t pending_items[$];
	reply_t   results_due[$];

	srt_pkg::entry_t model_rows[srt_pkg::TABLE_DEPTH];
	int     model_used = 0;

	int inputs_sent = 0;
	int inputs_taken = 0;
	int idle_cycles = 0;
	int fail_count = 0;
	int burst_left = 0;
	int gap_left = 0;

	rx_style_t   rx_style = RX_FREE;
	int          rx_span = 0;
	logic [15:0] rx_pattern = 16'hffff;
	int          hold_left = 0;
	bit          hold_done = 1'b0;

	sorted_reminder_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.year(year),
		.day(day),
		.hour(hour),
		.minute(minute),
		.tag(tag),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_year(out_year),
		.out_day(out_day),
		.out_hour(out_hour),
		.out_minute(out_minute),
		.out_tag(out_tag),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic request_t make_request(bit m, logic [13:0] y, logic [5:0] d,
			logic [4:0] h, logic [5:0] mi, logic [15:0] t);
		request_t r;
		r.mode = m;
		r.year = y;
		r.day = d;
		r.hour = h;
		r.minute = mi;
		r.tag = t;
		r.drain = 1'b0;
		return r;
	endfunction

	function automatic reply_t make_reply(srt_pkg::status_t st, srt_pkg::entry_t e,
			logic last_flag);
		reply_t r;
		r.status = st;
		r.year = e.year;
		r.day = e.day;
		r.hour = e.hour;
		r.minute = e.minute;
		r.tag = e.tag;
		r.last = last_flag;
		return r;
	endfunction

	// table behaviour: listing, full and range checks, ordered insert
	task automatic predict_results(input request_t rq);
		srt_pkg::entry_t fresh;
		int pos;
		if (rq.mode) begin
			if (model_used == 0) begin
				results_due.push_back(make_reply(srt_pkg::ST_EMPTY, '0, 1'b1));
			end else begin
				for (int j = 0; j < model_used; j++)
					results_due.push_back(make_reply(srt_pkg::ST_LISTED, model_rows[j],
						j == model_used - 1));
			end
		end else if (model_used >= srt_pkg::TABLE_DEPTH) begin
			results_due.push_back(make_reply(srt_pkg::ST_FULL, '0, 1'b1));
		end else if (rq.year == 0 || rq.year > srt_pkg::MAX_YEAR ||
				rq.day > srt_pkg::MAX_DAY || rq.hour >= srt_pkg::HOUR_LIMIT ||
				rq.minute >= srt_pkg::MINUTE_LIMIT) begin
			results_due.push_back(make_reply(srt_pkg::ST_INVALID, '0, 1'b1));
		end else begin
			fresh.year = rq.year;
			fresh.day = rq.day[4:0];
			fresh.hour = rq.hour;
			fresh.minute = rq.minute;
			fresh.tag = rq.tag;
			pos = 0;
			while (pos < model_used &&
					(model_rows[pos] >> $bits(fresh.tag)) < (fresh >> $bits(fresh.tag)))
				pos++;
			for (int j = model_used; j > pos; j--)
				model_rows[j] = model_rows[j - 1];
			model_rows[pos] = fresh;
			model_used++;
			results_due.push_back(make_reply(srt_pkg::ST_STORED, '0, 1'b1));
		end
	endtask

	// driver: bursts with random gaps, optional wait for an empty scoreboard
	always @(negedge clk) begin
		request_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && inputs_taken != inputs_sent) begin
			// item still on offer
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			in_valid <= 1'b0;
		end else if (pending_items.size() == 0 ||
				(pending_items[0].drain && results_due.size() != 0)) begin
			in_valid <= 1'b0;
		end else begin
			cur = pending_items.pop_front();
			mode <= cur.mode;
			year <= cur.year;
			day <= cur.day;
			hour <= cur.hour;
			minute <= cur.minute;
			tag <= cur.tag;
			in_valid <= 1'b1;
			inputs_sent <= inputs_sent + 1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 40);
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			end else begin
				burst_left <= burst_left - 1;
			end
		end
	end

	// receiver: changing stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_span == 0) begin
			rx_style <= rx_style_t'($urandom_range(0, 2));
			rx_span <= $urandom_range(10, 200);
			rx_pattern <= 16'($urandom);
			out_ready <= 1'b1;
		end else begin
			rx_span <= rx_span - 1;
			rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
			case (rx_style)
				RX_FREE: out_ready <= 1'b1;
				RX_PATTERN: out_ready <= rx_pattern[0];
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// monitor: check results, predict on accepted items, count idle cycles
	always @(posedge clk) begin
		reply_t want;
		request_t seen;
		if (out_valid && out_ready) begin
			if (results_due.size() == 0) begin
				$error("unexpected result: status %0d", status);
				fail_count++;
			end else begin
				want = results_due.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (out_year !== want.year) begin
					$error("out_year: expected %0d, got %0d", want.year, out_year);
					fail_count++;
				end
				if (out_day !== want.day) begin
					$error("out_day: expected %0d, got %0d", want.day, out_day);
					fail_count++;
				end
				if (out_hour !== want.hour) begin
					$error("out_hour: expected %0d, got %0d", want.hour, out_hour);
					fail_count++;
				end
				if (out_minute !== want.minute) begin
					$error("out_minute: expected %0d, got %0d", want.minute, out_minute);
					fail_count++;
				end
				if (out_tag !== want.tag) begin
					$error("out_tag: expected %0h, got %0h", want.tag, out_tag);
					fail_count++;
				end
				if (last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, last);
					fail_count++;
				end
			end
		end
		if (in_valid && in_ready) begin
			seen = make_request(mode, year, day, hour, minute, tag);
			predict_results(seen);
			inputs_taken <= inputs_taken + 1;
		end
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		request_t rq;
		int valid_made;
		int kind;
		bit full_now;
		valid_made = 0;

		// empty listing, each range violation, key extremes, equal keys
		pending_items.push_back(make_request(1'b1, 14'd0, 6'd0, 5'd0, 6'd0, 16'h0000));
		pending_items.push_back(make_request(1'b0, 14'd0, 6'd10, 5'd10, 6'd10, 16'h0001));
		pending_items.push_back(make_request(1'b0, 14'd10000, 6'd10, 5'd10, 6'd10, 16'h0002));
		pending_items.push_back(make_request(1'b0, 14'h3fff, 6'h3f, 5'd10, 6'd10, 16'h0003));
		pending_items.push_back(make_request(1'b0, 14'd2020, 6'd32, 5'd10, 6'd10, 16'h0004));
		pending_items.push_back(make_request(1'b0, 14'd2020, 6'd10, 5'd24, 6'd10, 16'h0005));
		pending_items.push_back(make_request(1'b0, 14'd2020, 6'd10, 5'h1f, 6'd10, 16'h0006));
		pending_items.push_back(make_request(1'b0, 14'd2020, 6'd10, 5'd10, 6'd60, 16'h0007));
		pending_items.push_back(make_request(1'b0, 14'd2020, 6'd10, 5'd10, 6'h3f, 16'h0008));
		pending_items.push_back(make_request(1'b0, 14'd9999, 6'd31, 5'd23, 6'd59, 16'hffff));
		pending_items.push_back(make_request(1'b0, 14'd1, 6'd0, 5'd0, 6'd0, 16'h0000));
		pending_items.push_back(make_request(1'b0, 14'd2024, 6'd15, 5'd12, 6'd30, 16'h1111));
		pending_items.push_back(make_request(1'b0, 14'd2024, 6'd15, 5'd12, 6'd30, 16'h2222));
		pending_items.push_back(make_request(1'b0, 14'd2024, 6'd15, 5'd12, 6'd30, 16'h3333));
		pending_items.push_back(make_request(1'b0, 14'd1, 6'd0, 5'd0, 6'd0, 16'h5555));
		pending_items.push_back(make_request(1'b0, 14'd9999, 6'd31, 5'd23, 6'd59, 16'haaaa));
		rq = make_request(1'b1, 14'd0, 6'd0, 5'd0, 6'd0, 16'h0000);
		rq.drain = 1'b1;
		pending_items.push_back(rq);
		pending_items.push_back(make_request(1'b1, 14'h3fff, 6'h3f, 5'h1f, 6'h3f, 16'hffff));
		valid_made = 7;

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			full_now = valid_made >= srt_pkg::TABLE_DEPTH;
			rq = make_request(1'b0, 14'($urandom_range(1, srt_pkg::MAX_YEAR)),
				6'($urandom_range(0, srt_pkg::MAX_DAY)),
				5'($urandom_range(0, srt_pkg::HOUR_LIMIT - 1)),
				6'($urandom_range(0, srt_pkg::MINUTE_LIMIT - 1)),
				16'($urandom_range(0, 16'hffff)));
			if (kind < (full_now ? 40 : 15)) begin
				rq = make_request(1'b1, 14'($urandom_range(0, 14'h3fff)),
					6'($urandom_range(0, 6'h3f)), 5'($urandom_range(0, 5'h1f)),
					6'($urandom_range(0, 6'h3f)), 16'($urandom_range(0, 16'hffff)));
			end else if (kind < (full_now ? 70 : 88)) begin
				// crowded keys so equal and neighbouring entries turn up
				if ($urandom_range(0, 2) == 0) begin
					rq.year = 14'd2000 + 14'($urandom_range(0, 1));
					rq.day = 6'($urandom_range(1, 2));
					rq.hour = 5'($urandom_range(0, 1));
					rq.minute = 6'($urandom_range(0, 1));
				end
				if (!full_now)
					valid_made++;
			end else begin
				rq.tag = 16'($urandom_range(0, 16'hffff));
				case ($urandom_range(0, 4))
					0: rq.year = ($urandom_range(0, 1) == 0) ? 14'd0 :
						14'($urandom_range(srt_pkg::MAX_YEAR + 1, 14'h3fff));
					1: rq.day = 6'($urandom_range(srt_pkg::MAX_DAY + 1, 6'h3f));
					2: rq.hour = 5'($urandom_range(srt_pkg::HOUR_LIMIT, 5'h1f));
					3: rq.minute = 6'($urandom_range(srt_pkg::MINUTE_LIMIT, 6'h3f));
					default: begin
						rq.year = 14'($urandom_range(0, 14'h3fff));
						rq.day = 6'($urandom_range(0, 6'h3f));
						rq.hour = 5'($urandom_range(0, 5'h1f));
						rq.minute = 6'($urandom_range(0, 6'h3f));
						if (!full_now && rq.year != 0 && rq.year <= srt_pkg::MAX_YEAR &&
								rq.day <= srt_pkg::MAX_DAY &&
								rq.hour < srt_pkg::HOUR_LIMIT &&
								rq.minute < srt_pkg::MINUTE_LIMIT)
							valid_made++;
					end
				endcase
			end
			rq.drain = (n % 97 == 50);
			pending_items.push_back(rq);
		end

		repeat (12) @(posedge clk);
		#0.5 arst_n = 1'b1;

		while (pending_items.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
